[rtl/quaternion_to_euler_angles_assert.svh]
// assertion macros used by the rtl of the quaternion to euler block
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication
`define QTE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/qte_pkg.sv]
`timescale 1ns / 1ps
package qte_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_STEPS = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
	localparam int CW = 38;
	localparam int RAD_W = 57;
	localparam int ROOT_W = 29;
	localparam int SQ_STEPS = 29;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GIMBAL_THRESHOLD = 2'd1;

	localparam logic signed [CW-1:0] HALF = CW'(64'sd134217728);
	localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << 56;

	localparam logic [31:0] ATAN_TAB [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680350, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] heading_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] bank_angle;
		logic gimbal_lock;
	} euler_t;

	// operands that ride along the square root pipeline
	typedef struct packed {
		logic signed [CW-1:0] hd;
		logic signed [CW-1:0] hn;
		logic signed [CW-1:0] bd;
		logic signed [CW-1:0] bn;
		logic signed [CW-1:0] pn;
		logic gimbal;
		logic signed [15:0] pclamp;
	} side_t;
endpackage

[rtl/qte_sqrt.sv]
`timescale 1ns / 1ps
module qte_sqrt import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input logic [RAD_W-1:0] rad,
	input side_t side_in,
	output logic vld_out,
	output logic [ROOT_W-1:0] root,
	output side_t side_out
);
	logic vld_s [SQ_STEPS];
	logic [RAD_W-1:0] rem_s [SQ_STEPS];
	logic [RAD_W:0] res_s [SQ_STEPS];
	side_t side_s [SQ_STEPS];

	// one result bit per stage, bit weight 4^(steps-1-k)
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (2 * (SQ_STEPS - 1 - k));
		logic vld_i;
		logic [RAD_W-1:0] rem_i;
		logic [RAD_W:0] res_i;
		logic [RAD_W:0] trial;
		side_t side_i;

		if (k == 0) begin : g_first
			assign vld_i = vld_in;
			assign rem_i = rad;
			assign res_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign vld_i = vld_s[k-1];
			assign rem_i = rem_s[k-1];
			assign res_i = res_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = res_i + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_i;
				if ({1'b0, rem_i} >= trial) begin
					rem_s[k] <= rem_i - trial[RAD_W-1:0];
					res_s[k] <= (res_i >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_i;
					res_s[k] <= res_i >> 1;
				end
			end
		end
	end

	assign vld_out = vld_s[SQ_STEPS-1];
	assign root = res_s[SQ_STEPS-1][ROOT_W-1:0];
	assign side_out = side_s[SQ_STEPS-1];
endmodule

[rtl/qte_cordic.sv]
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input logic signed [CW-1:0] d_in,
	input logic signed [CW-1:0] n_in,
	output logic vld_out,
	output logic signed [15:0] angle
);
	logic vld_s0;
	logic signed [CW-1:0] d_s0, n_s0;
	logic [31:0] acc_s0;
	logic vld_s [CORDIC_STEPS];
	logic signed [CW-1:0] d_s [CORDIC_STEPS];
	logic signed [CW-1:0] n_s [CORDIC_STEPS];
	logic [31:0] acc_s [CORDIC_STEPS];
	logic [31:0] acc_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= vld_in;
		end
	end

	// left half plane: flip the vector and start at pi
	always_ff @(posedge clk) begin
		if (en) begin
			if (d_in[CW-1]) begin
				d_s0 <= -d_in;
				n_s0 <= -n_in;
				acc_s0 <= 32'h8000_0000;
			end else begin
				d_s0 <= d_in;
				n_s0 <= n_in;
				acc_s0 <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		logic vld_i;
		logic signed [CW-1:0] d_i, n_i, dd, dn;
		logic [31:0] acc_i;

		if (i == 0) begin : g_first
			assign vld_i = vld_s0;
			assign d_i = d_s0;
			assign n_i = n_s0;
			assign acc_i = acc_s0;
		end else begin : g_next
			assign vld_i = vld_s[i-1];
			assign d_i = d_s[i-1];
			assign n_i = n_s[i-1];
			assign acc_i = acc_s[i-1];
		end

		assign dd = n_i >>> i;
		assign dn = d_i >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!n_i[CW-1]) begin
					d_s[i] <= d_i + dd;
					n_s[i] <= n_i - dn;
					acc_s[i] <= acc_i + ATAN_TAB[i];
				end else begin
					d_s[i] <= d_i - dd;
					n_s[i] <= n_i + dn;
					acc_s[i] <= acc_i - ATAN_TAB[i];
				end
			end
		end
	end

	// round to 16-bit binary angle, +pi wraps to -pi
	assign acc_rnd = acc_s[CORDIC_STEPS-1] + 32'h0000_8000;
	assign angle = acc_rnd[31:16];
	assign vld_out = vld_s[CORDIC_STEPS-1];
endmodule

[rtl/quaternion_to_euler_angles.sv]
`timescale 1ns / 1ps
// Quaternion (signed Q2.14) to heading, pitch and bank in 16-bit binary angle units.
// Fully pipelined: one quaternion is accepted every cycle unless the output stalls, and its
// result passes through the stages of products and sums, the bit-per-stage square root
// for the asin path, a quadrant fold stage and a stage for each CORDIC iteration, and the
// output register. A held result on the output freezes the whole pipeline until it is
// taken. The direction bit is applied to requests as they enter and the gimbal threshold
// at the gimbal decision stage, so write configuration only while the pipeline is empty.
module quaternion_to_euler_angles import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input quat_t in_data,
	output logic out_valid,
	input logic out_ready,
	output euler_t out_data,
	input logic cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [14:0] cfg_data
);
	`include "quaternion_to_euler_angles_assert.svh"

	typedef struct packed {
		logic gimbal;
		logic signed [15:0] pclamp;
	} tail_t;

	logic inverse_q;
	logic [14:0] threshold_q;
	logic en;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
			threshold_q <= 15'd16383;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_INVERSE_DIRECTION: inverse_q <= cfg_data[0];
				REG_GIMBAL_THRESHOLD: threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	euler_t out_q;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	// stage 1: products
	logic signed [16:0] w17, x17, y17, z17;
	logic vld_s1;
	logic signed [33:0] p_yz_s1, p_wx_s1, p_yy_s1, p_zz_s1, p_xx_s1;
	logic signed [33:0] p_wy_s1, p_xz_s1, p_xy_s1, p_wz_s1;

	assign w17 = inverse_q ? -17'(in_data.quat_w) : 17'(in_data.quat_w);
	assign x17 = 17'(in_data.quat_x);
	assign y17 = 17'(in_data.quat_y);
	assign z17 = 17'(in_data.quat_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_yz_s1 <= y17 * z17;
			p_wx_s1 <= w17 * x17;
			p_yy_s1 <= y17 * y17;
			p_zz_s1 <= z17 * z17;
			p_xx_s1 <= x17 * x17;
			p_wy_s1 <= w17 * y17;
			p_xz_s1 <= x17 * z17;
			p_xy_s1 <= x17 * y17;
			p_wz_s1 <= w17 * z17;
		end
	end

	// stage 2: sin pitch and the atan2 operands
	logic vld_s2;
	logic signed [35:0] dsp;
	logic signed [35:0] sp_s2;
	logic signed [CW-1:0] hdg_s2, hng_s2, hd_s2, hn_s2, bd_s2, bn_s2;

	assign dsp = 36'(p_wx_s1) - 36'(p_yz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s2 <= dsp <<< 1;
			hdg_s2 <= HALF - CW'(p_yy_s1) - CW'(p_zz_s1);
			hng_s2 <= CW'(p_wy_s1) - CW'(p_xz_s1);
			hd_s2 <= HALF - CW'(p_xx_s1) - CW'(p_yy_s1);
			hn_s2 <= CW'(p_xz_s1) + CW'(p_wy_s1);
			bd_s2 <= HALF - CW'(p_xx_s1) - CW'(p_zz_s1);
			bn_s2 <= CW'(p_xy_s1) + CW'(p_wz_s1);
		end
	end

	// stage 3: gimbal decision, clamp, sin squared
	logic signed [35:0] spr, sp14;
	logic [35:0] mag;
	logic gimbal;
	logic signed [15:0] pclamp;
	logic signed [28:0] sp29;
	logic vld_s3, in_range_s3;
	logic signed [57:0] sq_s3;
	side_t side_s3;

	assign spr = sp_s2 + 36'sd8192;
	assign sp14 = spr >>> 14;
	assign mag = sp14[35] ? 36'(-sp14) : 36'(sp14);
	assign gimbal = mag > 36'(threshold_q);
	assign sp29 = sp_s2[28:0];

	always_comb begin
		priority if (sp14 > 36'sd16384) begin
			pclamp = 16'sd16384;
		end else if (sp14 < -36'sd16384) begin
			pclamp = -16'sd16384;
		end else begin
			pclamp = sp14[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_range_s3 <= (sp_s2 < 36'sd268435456) && (sp_s2 > -36'sd268435456);
			sq_s3 <= sp29 * sp29;
			side_s3.hd <= gimbal ? hdg_s2 : hd_s2;
			side_s3.hn <= gimbal ? hng_s2 : hn_s2;
			side_s3.bd <= bd_s2;
			side_s3.bn <= bn_s2;
			side_s3.pn <= CW'(sp_s2);
			side_s3.gimbal <= gimbal;
			side_s3.pclamp <= pclamp;
		end
	end

	// stage 4: radicand for cos pitch, zero once |sin| reaches one
	logic vld_s4;
	logic [RAD_W-1:0] rad_s4;
	side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4 <= in_range_s3 ? RAD_ONE - sq_s3[RAD_W-1:0] : '0;
			side_s4 <= side_s3;
		end
	end

	logic vld_sq;
	logic [ROOT_W-1:0] root;
	side_t side_sq;

	qte_sqrt u_sqrt (
		.clk (clk),
		.arst_n (arst_n),
		.en (en),
		.vld_in (vld_s4),
		.rad (rad_s4),
		.side_in (side_s4),
		.vld_out (vld_sq),
		.root (root),
		.side_out (side_sq)
	);

	logic vld_c;
	logic signed [15:0] hang, pang, bang;

	qte_cordic u_heading (
		.clk (clk),
		.arst_n (arst_n),
		.en (en),
		.vld_in (vld_sq),
		.d_in (side_sq.hd),
		.n_in (side_sq.hn),
		.vld_out (),
		.angle (hang)
	);

	qte_cordic u_pitch (
		.clk (clk),
		.arst_n (arst_n),
		.en (en),
		.vld_in (vld_sq),
		.d_in (CW'(root)),
		.n_in (side_sq.pn),
		.vld_out (vld_c),
		.angle (pang)
	);

	qte_cordic u_bank (
		.clk (clk),
		.arst_n (arst_n),
		.en (en),
		.vld_in (vld_sq),
		.d_in (side_sq.bd),
		.n_in (side_sq.bn),
		.vld_out (),
		.angle (bang)
	);

	// gimbal flag and clamped pitch follow the cordic latency
	tail_t tail_s [CORDIC_STEPS+1];

	for (genvar k = 0; k <= CORDIC_STEPS; k++) begin : g_tail
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					tail_s[k] <= '{gimbal: side_sq.gimbal, pclamp: side_sq.pclamp};
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					tail_s[k] <= tail_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.heading_angle <= hang;
			out_q.pitch_angle <= tail_s[CORDIC_STEPS].gimbal ? tail_s[CORDIC_STEPS].pclamp : pang;
			out_q.bank_angle <= tail_s[CORDIC_STEPS].gimbal ? 16'sd0 : bang;
			out_q.gimbal_lock <= tail_s[CORDIC_STEPS].gimbal;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`QTE_ASSERT_IMP(a_bank_zero, out_valid_q && out_q.gimbal_lock, out_q.bank_angle == 16'sd0, "bank not zero in gimbal lock")
	`QTE_ASSERT_IMP(a_pitch_range, out_valid_q, (out_q.pitch_angle >= -16'sd16384) && (out_q.pitch_angle <= 16'sd16384), "pitch beyond pi/2")
	`QTE_ASSERT_NXT(a_stall_hold, !en, $stable(vld_s4) && $stable(rad_s4) && $stable(vld_c), "pipeline moved during stall")
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import qte_pkg::*;

	localparam int LATENCY = 35 + CORDIC_STAGES;
	localparam longint CYCLE_LIMIT = 200000;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	quat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	euler_t out_data;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [14:0] cfg_data = '0;

	quaternion_to_euler_angles dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	quat_t quat_queue[$];
	euler_t angles_due[$];
	int fail_count = 0;
	longint cycle_count = 0;
	bit inv_dir = 1'b0;
	logic [14:0] gimbal_thr = 15'd16383;
	int in_wait = 0;
	int out_wait = 0;

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	// cordic vectoring, 32-bit angle accumulator
	function automatic logic [31:0] vector_angle(longint d, longint n);
		logic [31:0] acc;
		longint dd, dn;
		acc = 32'd0;
		if (d < 0) begin
			d = -d;
			n = -n;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dd = fshr(n, i);
			dn = fshr(d, i);
			if (n >= 0) begin
				d += dd; n -= dn; acc += ATAN_TAB[i];
			end else begin
				d -= dd; n += dn; acc -= ATAN_TAB[i];
			end
		end
		return acc;
	endfunction

	function automatic logic [15:0] bam16(logic [31:0] a);
		logic [31:0] t;
		t = a + 32'h8000;
		return t[31:16];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic euler_t euler_of(quat_t q);
		euler_t r;
		longint w, x, y, z, sp, sp14, mag, c, p;
		longint half;
		w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
		half = 64'sd1 << 27;
		if (inv_dir) w = -w;
		sp = -2 * (y * z - w * x);
		sp14 = fshr(sp + 8192, 14);
		mag = sp14 < 0 ? -sp14 : sp14;
		if (mag > longint'(gimbal_thr)) begin
			p = sp14;
			if (p > 16384) p = 16384;
			if (p < -16384) p = -16384;
			r.heading_angle = bam16(vector_angle(half - y * y - z * z, w * y - x * z));
			r.pitch_angle = p[15:0];
			r.bank_angle = '0;
			r.gimbal_lock = 1'b1;
		end else begin
			c = 0;
			if (sp < (64'sd1 << 28) && sp > -(64'sd1 << 28))
				c = int_sqrt((64'd1 << 56) - longint'(sp * sp));
			r.heading_angle = bam16(vector_angle(half - x * x - y * y, x * z + w * y));
			r.pitch_angle = bam16(vector_angle(c, sp));
			r.bank_angle = bam16(vector_angle(half - x * x - z * z, x * y + w * z));
			r.gimbal_lock = 1'b0;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] unit_comp();
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	// random quaternion: mostly near unit length, some raw noise, some near gimbal
	function automatic quat_t random_quat();
		quat_t q;
		real a, b, cc, d, n;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			q = {$urandom, $urandom};
		end else if (sel < 4) begin
			// pitch near +-90: w*x - y*z near +-0.5
			q.quat_w = 16'(11585 + int'($urandom_range(0, 200)) - 100);
			q.quat_x = ($urandom_range(0, 1) ? 16'sd1 : -16'sd1)
				* 16'(11585 + int'($urandom_range(0, 200)) - 100);
			q.quat_y = 16'(int'($urandom_range(0, 400)) - 200);
			q.quat_z = 16'(int'($urandom_range(0, 400)) - 200);
		end else begin
			a = $itor(unit_comp()); b = $itor(unit_comp());
			cc = $itor(unit_comp()); d = $itor(unit_comp());
			n = $sqrt(a * a + b * b + cc * cc + d * d);
			if (n < 1.0) n = 1.0;
			q.quat_w = 16'($rtoi(a * 16384.0 / n));
			q.quat_x = 16'($rtoi(b * 16384.0 / n));
			q.quat_y = 16'($rtoi(cc * 16384.0 / n));
			q.quat_z = 16'($rtoi(d * 16384.0 / n));
		end
		return q;
	endfunction

	function automatic quat_t mk(int w, int x, int y, int z);
		quat_t q;
		q.quat_w = 16'(w); q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z);
		return q;
	endfunction

	// request driver
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (in_valid && in_ready) begin
			angles_due.push_back(euler_of(in_data));
			in_wait = $urandom_range(0, 3);
		end
		if (!in_valid || in_ready) begin
			if (in_wait > 0 || quat_queue.size() == 0 || !arst_n) begin
				in_valid <= 1'b0;
				if (in_wait > 0) in_wait--;
			end else begin
				in_valid <= 1'b1;
				in_data <= quat_queue.pop_front();
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		euler_t exp_r;
		if (out_valid && out_ready) begin
			if (angles_due.size() == 0) begin
				$error("result with no request pending");
				fail_count++;
			end else begin
				exp_r = angles_due.pop_front();
				if (out_data.heading_angle !== exp_r.heading_angle) begin
					$error("heading_angle exp %0d got %0d",
						exp_r.heading_angle, out_data.heading_angle);
					fail_count++;
				end
				if (out_data.pitch_angle !== exp_r.pitch_angle) begin
					$error("pitch_angle exp %0d got %0d",
						exp_r.pitch_angle, out_data.pitch_angle);
					fail_count++;
				end
				if (out_data.bank_angle !== exp_r.bank_angle) begin
					$error("bank_angle exp %0d got %0d",
						exp_r.bank_angle, out_data.bank_angle);
					fail_count++;
				end
				if (out_data.gimbal_lock !== exp_r.gimbal_lock) begin
					$error("gimbal_lock exp %0d got %0d",
						exp_r.gimbal_lock, out_data.gimbal_lock);
					fail_count++;
				end
			end
			out_wait = $urandom_range(0, 3);
		end
		if (out_wait > 0) begin
			out_ready <= 1'b0;
			out_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// checked away from the rising edge so the driver's updates are settled
	task automatic wait_drained();
		while (quat_queue.size() != 0 || in_valid || angles_due.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [14:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_INVERSE_DIRECTION) inv_dir = val[0];
		else if (idx == REG_GIMBAL_THRESHOLD) gimbal_thr = val;
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) quat_queue.push_back(random_quat());
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, identity, gimbal, zero vector, sine beyond one
		quat_queue.push_back(mk(16384, 0, 0, 0));
		quat_queue.push_back(mk(0, 0, 0, 0));
		quat_queue.push_back(mk(11585, 11585, 0, 0));
		quat_queue.push_back(mk(11585, -11585, 0, 0));
		quat_queue.push_back(mk(32767, 32767, 32767, 32767));
		quat_queue.push_back(mk(-32768, -32768, -32768, -32768));
		quat_queue.push_back(mk(-32768, 32767, -32768, 32767));
		quat_queue.push_back(mk(32767, -32768, 0, 0));
		quat_queue.push_back(mk(0, 0, 32767, -32768));
		quat_queue.push_back(mk(0, 16384, 0, 0));
		quat_queue.push_back(mk(0, 0, 16384, 0));
		quat_queue.push_back(mk(0, 0, 0, 16384));
		quat_queue.push_back(mk(8192, 8192, 8192, 8192));
		quat_queue.push_back(mk(-1, -1, -1, -1));
		quat_queue.push_back(mk(1, 1, 1, 1));
		quat_queue.push_back(mk(-16384, 0, 0, 0));
		wait_drained();
		run_random(200);
		write_reg(REG_INVERSE_DIRECTION, 15'd1);
		write_reg(REG_GIMBAL_THRESHOLD, 15'd16000);
		quat_queue.push_back(mk(11585, 11585, 0, 0));
		run_random(150);
		write_reg(REG_GIMBAL_THRESHOLD, 15'd0);
		run_random(100);
		write_reg(REG_INVERSE_DIRECTION, 15'd0);
		write_reg(REG_GIMBAL_THRESHOLD, 15'd16384);
		run_random(120);
		write_reg(REG_GIMBAL_THRESHOLD, 15'h7FFF);
		write_reg(REG_UNMAPPED, 15'd5);
		run_random(120);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
